FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

FILE: design/afvm_pkg.sv
package afvm_pkg;

    // item fields
    localparam int ADC_W  = 12;
    localparam int TIME_W = 32;
    localparam int VIN_W  = 17;

    localparam int IN_FW  = ADC_W + TIME_W;
    localparam int IN_DW  = ((IN_FW + 7) / 8) * 8;
    localparam int OUT_FW = 1 + VIN_W + 1;
    localparam int OUT_DW = ((OUT_FW + 7) / 8) * 8;

    // configuration
    localparam int POLL_W  = 16;
    localparam int START_W = 16;
    localparam int THR_W   = 17;
    localparam int DBR_W   = 8;
    localparam int DBM_W   = 22;
    localparam int CFG_DW  = 22;
    localparam int CFG_AW  = 3;

    localparam logic [POLL_W-1:0]  POLL_RST   = POLL_W'(500);
    localparam logic [START_W-1:0] START_RST  = START_W'(500);
    localparam logic [THR_W-1:0]   THR_RST    = THR_W'(1000);
    localparam logic [DBR_W-1:0]   DBR_RST    = DBR_W'(3);
    localparam logic [DBM_W-1:0]   DBM_RST    = DBM_W'(1500);
    localparam logic [POLL_W-1:0]  POLL_MIN   = POLL_W'(100);
    localparam logic [POLL_W-1:0]  POLL_MAX   = POLL_W'(60000);

    typedef enum logic [CFG_AW-1:0] {
        CFG_POLL     = 3'd0,
        CFG_START    = 3'd1,
        CFG_THRESH   = 3'd2,
        CFG_DB_READS = 3'd3,
        CFG_DB_MS    = 3'd4
    } t_cfg_idx;

    // averaging window
    localparam int WIN_DEPTH = 8;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int TOTAL_W   = ADC_W + WIN_AW;

    // scaling: vin = (avg * SCALE_NUM + SCALE_RND) / SCALE_DEN
    localparam int SCALE_NUM = 2967;
    localparam int SCALE_DEN = 100;
    localparam int SCALE_RND = 50;
    localparam int PROD_W    = $clog2(((1 << ADC_W) - 1) * SCALE_NUM + SCALE_RND + 1);

    // serial divider
    localparam int DVD_W  = PROD_W;
    localparam int DSR_W  = $clog2(SCALE_DEN + 1);
    localparam int DCNT_W = $clog2(DVD_W);

    // serial multiplier
    localparam int MCNT_W = $clog2(ADC_W);

    // debounce
    localparam int LOWC_W = 8;
    localparam logic [LOWC_W-1:0] LOW_MAX = LOWC_W'(255);

    typedef struct packed {
        logic [FILL_W-1:0]  fill;
        logic [TOTAL_W-1:0] total;
    } t_win_stat;

endpackage

FILE: design/averaged_fuse_voltage_monitor_top.sv
// Averaged fuse voltage monitor. Each input word carries a converter reading
// (adc_mv, bits 11:0) and a millisecond timestamp (now_ms, bits 43:12). A
// reading is taken only once the time has reached the start-up delay (latched
// once) and the poll interval has passed since the last taken reading. Taken
// readings enter an 8-deep moving window; the truncated mean is scaled to
// input millivolts as round(avg*29.67) and checked against the fuse threshold
// with a debounce on both reading count and elapsed time. Every input word
// yields exactly one output word. A rejected reading goes straight to the
// output stage; a taken reading is first averaged and scaled by the
// bit-serial restoring divider (24 steps, run once for the mean and once for
// the divide by 100) and the 12-step bit-serial multiplier. The output word
// register lets a finished word wait while the next reading is taken in.
`include "assert_macros.svh"

module averaged_fuse_voltage_monitor_top import afvm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // adc_mv, now_ms
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // accepted, vin_mv, fuse_blown
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_AVG  = 6'b000010,
        S_MUL  = 6'b000100,
        S_SCL  = 6'b001000,
        S_JDG  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic                r_go, n_go;

    logic [POLL_W-1:0]   r_cfg_poll;
    logic [START_W-1:0]  r_cfg_start;
    logic [THR_W-1:0]    r_cfg_thr;
    logic [DBR_W-1:0]    r_cfg_dbr;
    logic [DBM_W-1:0]    r_cfg_dbm;

    logic                r_started;
    logic [TIME_W-1:0]   r_last;
    logic [TIME_W-1:0]   r_now;
    logic                r_take;
    logic [LOWC_W-1:0]   r_low_cnt;
    logic [TIME_W-1:0]   r_low_since;
    logic [VIN_W-1:0]    r_held_vin;
    logic                r_held_blown;
    logic                r_out_valid;
    logic [OUT_FW-1:0]   r_out_word;

    logic                in_acc;
    logic [ADC_W-1:0]    in_mv;
    logic [TIME_W-1:0]   in_now;
    logic [POLL_W-1:0]   poll_sat;
    logic                n_started;
    logic [TIME_W-1:0]   since_last;
    logic                take;
    logic                out_free;

    t_win_stat           win;
    logic                div_start;
    logic [DVD_W-1:0]    div_dvd;
    logic [DSR_W-1:0]    div_dsr;
    logic                div_done;
    logic [DVD_W-1:0]    div_quo;
    logic                mul_start;
    logic                mul_done;
    logic [PROD_W-1:0]   mul_prod;

    logic [VIN_W-1:0]    vin;
    logic                below;
    logic [LOWC_W-1:0]   n_low_cnt;
    logic [TIME_W-1:0]   n_low_since;
    logic [DBR_W-1:0]    need;
    logic                blown;

    // input side gating
    always_comb begin
        s_axis_tready = (r_state == S_IDLE) && i_rst_n;
        in_acc        = s_axis_tvalid && s_axis_tready;
        in_mv         = s_axis_tdata[ADC_W-1:0];
        in_now        = s_axis_tdata[ADC_W +: TIME_W];
        if (r_cfg_poll < POLL_MIN) begin
            poll_sat = POLL_MIN;
        end else if (r_cfg_poll > POLL_MAX) begin
            poll_sat = POLL_MAX;
        end else begin
            poll_sat = r_cfg_poll;
        end
        n_started  = r_started || (in_now >= TIME_W'(r_cfg_start));
        since_last = in_now - r_last;
        take       = n_started && (since_last >= TIME_W'(poll_sat));
        out_free   = !r_out_valid || m_axis_tready;
    end

    afvm_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc && take),
        .i_mv    (in_mv),
        .o_stat  (win)
    );

    // one divider serves the mean and the divide by 100
    always_comb begin
        div_start = r_go && ((r_state == S_AVG) || (r_state == S_SCL));
        mul_start = r_go && (r_state == S_MUL);
        if (r_state == S_SCL) begin
            div_dvd = mul_prod;
            div_dsr = DSR_W'(SCALE_DEN);
        end else begin
            div_dvd = DVD_W'(win.total);
            div_dsr = DSR_W'(win.fill);
        end
    end

    afvm_sdiv u_sdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    afvm_smul u_smul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (div_quo[ADC_W-1:0]),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    // debounce judgement on the fresh scaled value
    always_comb begin
        vin   = div_quo[VIN_W-1:0];
        below = (vin <= r_cfg_thr);
        if (below) begin
            n_low_since = (r_low_since == '0) ? r_now : r_low_since;
            n_low_cnt   = (r_low_cnt == LOW_MAX) ? r_low_cnt : (r_low_cnt + 1'b1);
        end else begin
            n_low_since = '0;
            n_low_cnt   = '0;
        end
        need  = (r_cfg_dbr == '0) ? DBR_W'(1) : r_cfg_dbr;
        blown = (n_low_cnt >= need) && (n_low_since != '0)
                && ((r_now - n_low_since) >= TIME_W'(r_cfg_dbm));
    end

    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = take ? S_AVG : S_OUT;
                    n_go    = take;
                end
            end
            S_AVG: begin
                if (div_done) begin
                    n_state = S_MUL;
                    n_go    = 1'b1;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_state = S_SCL;
                    n_go    = 1'b1;
                end
            end
            S_SCL: begin
                if (div_done) begin
                    n_state = S_JDG;
                end
            end
            S_JDG: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_go         <= 1'b0;
            r_started    <= 1'b0;
            r_last       <= '0;
            r_take       <= 1'b0;
            r_low_cnt    <= '0;
            r_low_since  <= '0;
            r_held_vin   <= '0;
            r_held_blown <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            if (in_acc) begin
                r_started <= n_started;
                r_take    <= take;
                if (take) begin
                    r_last <= in_now;
                end
            end
            if (r_state == S_JDG) begin
                r_low_cnt    <= n_low_cnt;
                r_low_since  <= n_low_since;
                r_held_vin   <= vin;
                r_held_blown <= blown;
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now <= in_now;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out_word <= {r_held_blown, r_held_vin, r_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_poll  <= POLL_RST;
            r_cfg_start <= START_RST;
            r_cfg_thr   <= THR_RST;
            r_cfg_dbr   <= DBR_RST;
            r_cfg_dbm   <= DBM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_POLL:     r_cfg_poll  <= i_cfg_wdata[POLL_W-1:0];
                CFG_START:    r_cfg_start <= i_cfg_wdata[START_W-1:0];
                CFG_THRESH:   r_cfg_thr   <= i_cfg_wdata[THR_W-1:0];
                CFG_DB_READS: r_cfg_dbr   <= i_cfg_wdata[DBR_W-1:0];
                CFG_DB_MS:    r_cfg_dbm   <= i_cfg_wdata[DBM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DW'(r_out_word);

    `ASSERT_CLK(a_div_start_state, i_clk, i_rst_n, div_start |-> (r_state == S_AVG || r_state == S_SCL))
    `ASSERT_CLK(a_blown_has_lows, i_clk, i_rst_n, r_held_blown |-> (r_low_cnt != '0))
    `ASSERT_CLK(a_low_since_clear, i_clk, i_rst_n, (r_low_cnt == '0) |-> (r_low_since == '0))

endmodule

FILE: design/afvm_window.sv
module afvm_window import afvm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [ADC_W-1:0] i_mv,
    output t_win_stat        o_stat
);

    logic [ADC_W-1:0]   r_smp [WIN_DEPTH];
    logic [FILL_W-1:0]  r_fill;
    logic [WIN_AW-1:0]  r_pos;
    logic [TOTAL_W-1:0] r_total;

    logic               full;
    logic [TOTAL_W-1:0] mv_ext;
    logic [TOTAL_W-1:0] old_ext;
    logic [TOTAL_W-1:0] n_total;
    logic [FILL_W-1:0]  n_fill;
    logic [WIN_AW-1:0]  n_pos;

    always_comb begin
        full    = (r_fill == FILL_W'(WIN_DEPTH));
        mv_ext  = TOTAL_W'(i_mv);
        old_ext = TOTAL_W'(r_smp[r_pos]);
        // oldest entry drops out once the window is full
        n_total = full ? (r_total - old_ext + mv_ext) : (r_total + mv_ext);
        n_fill  = full ? r_fill : (r_fill + 1'b1);
        n_pos   = (r_pos == WIN_AW'(WIN_DEPTH - 1)) ? '0 : (r_pos + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_pos   <= '0;
            r_total <= '0;
        end else if (i_push) begin
            r_fill  <= n_fill;
            r_pos   <= n_pos;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_smp[r_pos] <= i_mv;
        end
    end

    assign o_stat.fill  = r_fill;
    assign o_stat.total = r_total;

endmodule

FILE: design/afvm_sdiv.sv
`include "assert_macros.svh"

// restoring divider, one quotient bit per cycle, MSB first
module afvm_sdiv import afvm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DSR_W-1:0]  r_rem;
    logic [DSR_W-1:0]  r_dsr;
    logic [DVD_W-1:0]  r_quo;

    logic [DSR_W:0]    trial;
    logic [DSR_W:0]    diff;
    logic              ge;
    logic [DSR_W-1:0]  n_rem;
    logic              last;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dsr};
        ge    = (trial >= {1'b0, r_dsr});
        n_rem = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        last  = (r_cnt == DCNT_W'(DVD_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_busy <= !last;
            r_done <= last;
        end else begin
            r_done <= 1'b0;
        end
    end

    // dividend bits leave at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `ASSERT_NEVER(a_start_while_busy, i_clk, i_rst_n, i_start && r_busy)
    `ASSERT_CLK(a_done_after_busy, i_clk, i_rst_n, r_done |-> (!r_busy && $past(r_busy)))
    `ASSERT_CLK(a_cnt_range, i_clk, i_rst_n, r_busy |-> (r_cnt <= DCNT_W'(DVD_W - 1)))

endmodule

FILE: design/afvm_smul.sv
// shift-add multiply by the scale numerator, one multiplier bit per cycle,
// accumulator seeded with the rounding term
module afvm_smul import afvm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADC_W-1:0]  i_mcand,
    output logic              o_done,
    output logic [PROD_W-1:0] o_product
);

    logic              r_busy;
    logic              r_done;
    logic [MCNT_W-1:0] r_cnt;
    logic [ADC_W-1:0]  r_bits;
    logic [PROD_W-1:0] r_addend;
    logic [PROD_W-1:0] r_acc;

    logic              last;

    assign last = (r_cnt == MCNT_W'(ADC_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_busy <= !last;
            r_done <= last;
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bits   <= i_mcand;
            r_addend <= PROD_W'(SCALE_NUM);
            r_acc    <= PROD_W'(SCALE_RND);
        end else if (r_busy) begin
            r_bits   <= r_bits >> 1;
            r_addend <= r_addend << 1;
            if (r_bits[0]) begin
                r_acc <= r_acc + r_addend;
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule
